// ===== rtl/mksl_pkg.sv =====
`default_nettype none

package mksl_pkg;

    // matrix geometry and counter size
    localparam int NUM_KEYS    = 12;
    localparam int NUM_ROWS    = 4;
    localparam int NUM_COLUMNS = 3;
    localparam int COUNT_WIDTH = 16;

    // field widths
    localparam int PHASE_W = 2;
    localparam int DRIVE_W = 3;
    localparam int KIND_W  = 2;
    localparam int KEY_W   = 4;
    localparam int THR_W   = 16;
    localparam int CFG_W   = 2;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // function codes of an input word
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // register indexes
    localparam logic [CFG_W-1:0] REG_PRESS_THR     = 2'd0;
    localparam logic [CFG_W-1:0] REG_LONG_THR      = 2'd1;
    localparam logic [CFG_W-1:0] REG_VERY_LONG_THR = 2'd2;

    // register reset values
    localparam logic [THR_W-1:0] PRESS_THR_RST     = 16'd3;
    localparam logic [THR_W-1:0] LONG_THR_RST      = 16'd133;
    localparam logic [THR_W-1:0] VERY_LONG_THR_RST = 16'd333;

    // event codes
    typedef enum logic [KIND_W-1:0] {
        EV_NONE      = 2'd0,
        EV_PRESS     = 2'd1,
        EV_LONG      = 2'd2,
        EV_VERY_LONG = 2'd3
    } event_kind_t;

    // one result word
    typedef struct packed {
        logic [DRIVE_W-1:0] drive;
        event_kind_t        kind;
        logic [KEY_W-1:0]   key;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/matrix_keypad_scan_long_press_top.sv =====
`default_nettype none

// Matrix keypad scanner, 3 columns by 4 active-low rows, with debounce and
// long-press detection.
// Input channel (in_valid/in_ready): func selects a scan tick (row_sense holds
// the rows sampled under the last column_drive) or a read of the first
// pending key event. Every input word yields exactly one result word.
// Output channel (out_valid/out_ready): column_drive to apply before the next
// tick, event_kind and key_index (both zero on a tick or an empty read).
// Config channel (cfg_valid/cfg_ready, always ready): cfg_index 0..2 writes
// the press, long and very-long thresholds; index 3 is ignored. Write only
// while no result is outstanding.
// Results are registered; one word is accepted every cycle while in_ready is
// high. All twelve hold counters and the event priority logic work in the
// accepting cycle, so a new word can follow in the very next cycle.
// When the receiver stalls, a one-word skid register still takes the next
// word; with both the output and skid registers full, in_ready drops.
// Reset (rst_n low, asynchronous) clears counters, event latches and the
// scan position, loads the default thresholds and empties the output side.
module matrix_keypad_scan_long_press_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        func,
    input  wire logic [3:0]                  row_sense,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [mksl_pkg::DRIVE_W-1:0]     column_drive,
    output logic [mksl_pkg::KIND_W-1:0]      event_kind,
    output logic [mksl_pkg::KEY_W-1:0]       key_index,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [mksl_pkg::CFG_W-1:0]  cfg_index,
    input  wire logic [mksl_pkg::THR_W-1:0]  cfg_data
);

    import mksl_pkg::*;

    logic [THR_W-1:0]       press_thr_reg;
    logic [THR_W-1:0]       long_thr_reg;
    logic [THR_W-1:0]       very_long_thr_reg;

    logic [PHASE_W-1:0]     scan_phase_reg;
    logic [PHASE_W-1:0]     scan_phase_next;
    logic [NUM_KEYS-1:0]    sample_shift_reg;
    logic [NUM_KEYS-1:0]    sample_shift_next;
    logic [COUNT_WIDTH-1:0] hold_count_reg [NUM_KEYS];
    logic [COUNT_WIDTH-1:0] hold_count_next [NUM_KEYS];
    logic [NUM_KEYS-1:0]    pressed_reg;
    logic [NUM_KEYS-1:0]    pressed_next;
    logic [NUM_KEYS-1:0]    long_reg;
    logic [NUM_KEYS-1:0]    long_next;
    logic [NUM_KEYS-1:0]    very_long_reg;
    logic [NUM_KEYS-1:0]    very_long_next;

    logic                   out_valid_reg;
    logic                   skid_valid_reg;
    result_t                out_reg;
    result_t                skid_reg;
    result_t                result;

    logic                   accept;
    logic                   load_out;

    // tick datapath signals
    logic                   restart;
    logic [PHASE_W-1:0]     phase_in;
    logic [NUM_KEYS-1:0]    shift_in;
    logic [NUM_KEYS-1:0]    shift_new;
    logic [PHASE_W-1:0]     phase_inc;
    logic                   scan_done;

    // read datapath signals
    logic                   found;
    event_kind_t            read_kind;
    logic [KEY_W-1:0]       read_key;

    assign accept    = in_valid && in_ready;
    assign in_ready  = !skid_valid_reg;
    assign cfg_ready = 1'b1;
    assign load_out  = !out_valid_reg || out_ready;

    // scan position and key image for a tick
    always_comb
    begin
        restart   = (scan_phase_reg >= PHASE_W'(NUM_COLUMNS));
        phase_in  = restart ? '0 : scan_phase_reg;
        shift_in  = restart ? '1 : sample_shift_reg;
        shift_new = NUM_KEYS'({shift_in, row_sense[NUM_ROWS-1:0]});
        phase_inc = phase_in + PHASE_W'(1);
        scan_done = (phase_inc == PHASE_W'(NUM_COLUMNS));
    end

    // first pending event in key order, press before long before very long
    always_comb
    begin
        found     = 1'b0;
        read_kind = EV_NONE;
        read_key  = '0;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            if (!found)
            begin
                if (pressed_reg[k])
                begin
                    found     = 1'b1;
                    read_kind = EV_PRESS;
                    read_key  = KEY_W'(k);
                end
                else if (long_reg[k])
                begin
                    found     = 1'b1;
                    read_kind = EV_LONG;
                    read_key  = KEY_W'(k);
                end
                else if (very_long_reg[k])
                begin
                    found     = 1'b1;
                    read_kind = EV_VERY_LONG;
                    read_key  = KEY_W'(k);
                end
            end
        end
    end

    // next state and result for the accepted word
    always_comb
    begin
        logic [COUNT_WIDTH-1:0] cnt;
        scan_phase_next   = scan_phase_reg;
        sample_shift_next = sample_shift_reg;
        pressed_next      = pressed_reg;
        long_next         = long_reg;
        very_long_next    = very_long_reg;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            hold_count_next[k] = hold_count_reg[k];
        end
        cnt = '0;

        if (func == FUNC_TICK)
        begin
            if (scan_done)
            begin
                scan_phase_next   = '0;
                sample_shift_next = '1;
                // evaluate every key of the completed scan
                for (int k = 0; k < NUM_KEYS; k++)
                begin
                    cnt = shift_new[k] ? '0 : hold_count_reg[k];
                    if (cnt == COUNT_WIDTH'(press_thr_reg))
                    begin
                        pressed_next[k] = 1'b1;
                    end
                    if (cnt == COUNT_WIDTH'(long_thr_reg))
                    begin
                        long_next[k] = 1'b1;
                    end
                    if (cnt == COUNT_WIDTH'(very_long_thr_reg))
                    begin
                        very_long_next[k] = 1'b1;
                    end
                    hold_count_next[k] = (cnt == COUNT_MAX) ? cnt
                                                           : cnt + COUNT_WIDTH'(1);
                end
            end
            else
            begin
                scan_phase_next   = phase_inc;
                sample_shift_next = shift_new;
            end
        end
        else
        begin
            case (read_kind)
                EV_PRESS:     pressed_next   = '0;
                EV_LONG:      long_next      = '0;
                EV_VERY_LONG: very_long_next = '0;
                default:      ;
            endcase
        end

        // column drive follows the phase after this word
        result.drive = '1;
        if (scan_phase_next < PHASE_W'(NUM_COLUMNS))
        begin
            result.drive[scan_phase_next] = 1'b0;
        end
        result.kind = (func == FUNC_READ) ? read_kind : EV_NONE;
        result.key  = (func == FUNC_READ) ? read_key : '0;
    end

    // threshold registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_thr_reg     <= PRESS_THR_RST;
            long_thr_reg      <= LONG_THR_RST;
            very_long_thr_reg <= VERY_LONG_THR_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PRESS_THR:     press_thr_reg     <= cfg_data;
                REG_LONG_THR:      long_thr_reg      <= cfg_data;
                REG_VERY_LONG_THR: very_long_thr_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // scanner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_phase_reg   <= '0;
            sample_shift_reg <= '1;
            pressed_reg      <= '0;
            long_reg         <= '0;
            very_long_reg    <= '0;
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                hold_count_reg[k] <= '0;
            end
        end
        else if (accept)
        begin
            scan_phase_reg   <= scan_phase_next;
            sample_shift_reg <= sample_shift_next;
            pressed_reg      <= pressed_next;
            long_reg         <= long_next;
            very_long_reg    <= very_long_next;
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                hold_count_reg[k] <= hold_count_next[k];
            end
        end
    end

    // output register with one skid word behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg  <= skid_valid_reg || accept;
            skid_valid_reg <= skid_valid_reg && accept;
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
                if (accept)
                begin
                    skid_reg <= result;
                end
            end
            else if (accept)
            begin
                out_reg <= result;
            end
        end
        else if (accept)
        begin
            skid_reg <= result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign column_drive = out_reg.drive;
    assign event_kind   = out_reg.kind;
    assign key_index    = out_reg.key;

    // skid word only ever sits behind a full output register
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word without output word");

    // an empty event reports key zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (event_kind == EV_NONE)) |-> (key_index == '0))
        else $error("key index set without an event");

    // scan position stays within the columns
    assert property (@(posedge clk) disable iff (!rst_n)
        scan_phase_reg < PHASE_W'(NUM_COLUMNS))
        else $error("scan phase out of range");

    // a fresh scan starts from a blank key image
    assert property (@(posedge clk) disable iff (!rst_n)
        (scan_phase_reg == '0) |-> (sample_shift_reg == '1))
        else $error("key image not blank at scan start");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mksl_pkg::*;

    localparam int CLK_PERIOD = 10;
    // cfg index with no register behind it, writes are dropped
    localparam logic [CFG_W-1:0] REG_SPARE = 2'd3;
    localparam int MAX_SHOWN = 10;
    localparam int RANDOM_ITEMS_PER_PHASE = 630;

    // one input word waiting for the driver
    typedef struct {
        logic       fn;
        logic [3:0] rows;
    } key_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic func = FUNC_TICK;
    logic [3:0] row_sense = 4'hf;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [DRIVE_W-1:0] column_drive;
    logic [KIND_W-1:0] event_kind;
    logic [KEY_W-1:0] key_index;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_W-1:0] cfg_index = REG_PRESS_THR;
    logic [THR_W-1:0] cfg_data = '0;

    // traffic shaping
    int send_gap_pct = 17;
    int recv_stall_pct = 58;
    logic long_stall = 1'b0;

    key_word_t pending_key_words[$];
    result_t expected_key_reports[$];
    int accepted_words = 0;
    int mismatches = 0;

    // scanner mirror: thresholds, scan position, key image, counters, latches
    logic [THR_W-1:0] press_thr = PRESS_THR_RST;
    logic [THR_W-1:0] long_thr = LONG_THR_RST;
    logic [THR_W-1:0] very_long_thr = VERY_LONG_THR_RST;
    logic [PHASE_W-1:0] scan_pos = '0;
    logic [NUM_KEYS-1:0] key_image = '1;
    logic [COUNT_WIDTH-1:0] held_scans[NUM_KEYS];
    logic [NUM_KEYS-1:0] press_latch = '0;
    logic [NUM_KEYS-1:0] long_latch = '0;
    logic [NUM_KEYS-1:0] very_long_latch = '0;

    // stimulus side view of the matrix
    int gen_col = 0;
    logic [NUM_KEYS-1:0] pressed_keys = '0;

    matrix_keypad_scan_long_press_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .row_sense    (row_sense),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .column_drive (column_drive),
        .event_kind   (event_kind),
        .key_index    (key_index),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // mirror of the scanner for one accepted word
    task automatic predict_keypad_word(input logic fn, input logic [3:0] rows,
                                       output result_t r);
        r.kind = EV_NONE;
        r.key = '0;
        if (fn == FUNC_TICK) begin
            // a stray phase restarts the scan at column 0
            if (scan_pos >= NUM_COLUMNS) begin
                scan_pos = '0;
                key_image = '1;
            end
            key_image = {key_image[NUM_KEYS-NUM_ROWS-1:0], rows};
            scan_pos = scan_pos + 1'b1;
            if (scan_pos == NUM_COLUMNS) begin
                // full image: clear released keys, compare, then count up
                for (int k = 0; k < NUM_KEYS; k++) begin
                    if (key_image[k])
                        held_scans[k] = '0;
                    if (held_scans[k] == press_thr)
                        press_latch[k] = 1'b1;
                    if (held_scans[k] == long_thr)
                        long_latch[k] = 1'b1;
                    if (held_scans[k] == very_long_thr)
                        very_long_latch[k] = 1'b1;
                    if (held_scans[k] != COUNT_MAX)
                        held_scans[k] = held_scans[k] + 1'b1;
                end
                key_image = '1;
                scan_pos = '0;
            end
        end else begin
            // first pending event by key, press before long before very long
            for (int k = 0; k < NUM_KEYS && r.kind == EV_NONE; k++) begin
                if (press_latch[k]) begin
                    press_latch = '0;
                    r.kind = EV_PRESS;
                end else if (long_latch[k]) begin
                    long_latch = '0;
                    r.kind = EV_LONG;
                end else if (very_long_latch[k]) begin
                    very_long_latch = '0;
                    r.kind = EV_VERY_LONG;
                end
                if (r.kind != EV_NONE)
                    r.key = KEY_W'(k);
            end
        end
        r.drive = (scan_pos >= NUM_COLUMNS) ? '1 : ~(DRIVE_W'(1) << scan_pos);
    endtask

    task automatic note_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
    endtask

    // input driver: presents queued words, random gaps between them
    always @(posedge clk) begin
        key_word_t w;
        result_t r;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                predict_keypad_word(func, row_sense, r);
                expected_key_reports.push_back(r);
                accepted_words++;
            end
            if (!in_valid || in_ready) begin
                if (pending_key_words.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    w = pending_key_words.pop_front();
                    in_valid <= 1'b1;
                    func <= w.fn;
                    row_sense <= w.rows;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output ready with random stalls and one long hold-off
    always @(posedge clk) begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !long_stall && ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor: compare each result word with the oldest prediction
    always @(posedge clk) begin
        result_t want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_key_reports.size() == 0) begin
                note_mismatch("unexpected word, column_drive", -1, column_drive);
            end else begin
                want = expected_key_reports.pop_front();
                if (column_drive !== want.drive)
                    note_mismatch("column_drive", want.drive, column_drive);
                if (event_kind !== want.kind)
                    note_mismatch("event_kind", want.kind, event_kind);
                if (key_index !== want.key)
                    note_mismatch("key_index", want.key, key_index);
            end
        end
    end

    // hold the receiver off long enough for the input side to back up
    initial begin
        wait (accepted_words >= 300);
        @(posedge clk);
        long_stall <= 1'b1;
        repeat (400) @(posedge clk);
        long_stall <= 1'b0;
    end

    task automatic push_tick(input logic [3:0] rows);
        key_word_t w;
        w.fn = FUNC_TICK;
        w.rows = rows;
        pending_key_words.push_back(w);
        gen_col = (gen_col + 1) % NUM_COLUMNS;
    endtask

    task automatic push_read();
        key_word_t w;
        w.fn = FUNC_READ;
        w.rows = 4'($urandom_range(15));
        pending_key_words.push_back(w);
    endtask

    // rows seen under the current column for the held key set
    function automatic logic [3:0] column_rows(input logic [NUM_KEYS-1:0] held);
        return ~held[(NUM_COLUMNS - 1 - gen_col) * NUM_ROWS +: NUM_ROWS];
    endfunction

    // sampled after the edge so that words just handed over are seen
    task automatic wait_idle();
        @(negedge clk);
        while (pending_key_words.size() != 0 || in_valid || expected_key_reports.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [CFG_W-1:0] idx, input logic [THR_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_PRESS_THR:     press_thr = val;
            REG_LONG_THR:      long_thr = val;
            REG_VERY_LONG_THR: very_long_thr = val;
            default: ;
        endcase
    endtask

    task automatic set_thresholds(input logic [THR_W-1:0] p, input logic [THR_W-1:0] l,
                                  input logic [THR_W-1:0] v);
        write_threshold(REG_PRESS_THR, p);
        write_threshold(REG_LONG_THR, l);
        write_threshold(REG_VERY_LONG_THR, v);
    endtask

    // keys held for runs of scans, some contact bounce, reads mixed in
    task automatic push_random_items(input int count);
        logic [3:0] rows;
        int flip;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(7) == 0) begin
                push_read();
            end else begin
                if (gen_col == 0 && $urandom_range(5) == 0) begin
                    flip = $urandom_range(NUM_KEYS - 1);
                    pressed_keys[flip] = ~pressed_keys[flip];
                end
                rows = column_rows(pressed_keys);
                if ($urandom_range(39) == 0)
                    rows = 4'($urandom_range(15));
                push_tick(rows);
            end
        end
    endtask

    initial begin
        for (int k = 0; k < NUM_KEYS; k++)
            held_scans[k] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty read, released scan, all keys held to the press event
        push_read();
        repeat (NUM_COLUMNS) push_tick(4'hf);
        repeat (4 * NUM_COLUMNS) push_tick(4'h0);
        push_read();
        push_read();
        wait_idle();

        // directed: zero press threshold and the ignored spare register
        set_thresholds(16'd0, 16'd1, 16'd2);
        write_threshold(REG_SPARE, 16'hffff);
        repeat (NUM_COLUMNS) push_tick(4'hf);
        push_read();
        push_read();
        repeat (2) begin
            push_tick(4'hf);
            push_tick(4'hd);
            push_tick(4'hf);
        end
        repeat (3) push_read();
        wait_idle();

        // random, small thresholds
        set_thresholds(16'($urandom_range(1, 5)), 16'($urandom_range(6, 30)),
                       16'($urandom_range(31, 90)));
        push_random_items(RANDOM_ITEMS_PER_PHASE);
        wait_idle();

        // random, long press out of reach, receiver mostly ready
        send_gap_pct = 58;
        recv_stall_pct = 17;
        set_thresholds(16'($urandom_range(0, 3)), 16'hffff, 16'($urandom_range(8, 40)));
        push_random_items(RANDOM_ITEMS_PER_PHASE);
        wait_idle();

        // random, press and long on the same scan, no idling
        send_gap_pct = 0;
        recv_stall_pct = 0;
        press_thr = 16'($urandom_range(0, 4));
        set_thresholds(press_thr, press_thr, 16'($urandom_range(5, 50)));
        push_random_items(RANDOM_ITEMS_PER_PHASE);
        wait_idle();
        repeat (10) @(posedge clk);

        if (mismatches == 0 && expected_key_reports.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // run limit
    initial begin
        #500_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/mksl_pkg.sv
rtl/matrix_keypad_scan_long_press_top.sv
tb/sv/testbench.sv
